### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DNFB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DNFB_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DNFB_ASSERT(lbl, clk, rst_n, prop, msg)
`define DNFB_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/dnfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnfb_pkg
// Types and constants for the normal-map byte decoder.
// ----------------------------------------------------------------------------
package dnfb_pkg;
  localparam int OUT_BITS_DEF = 16;
  localparam int ABS_W        = 9;    // |4*b - 510| <= 510
  localparam int LEN2_W       = 20;   // 2*510^2 + 255^2 < 2^20
  localparam int FIFO_DEPTH   = 2;
  localparam logic [ABS_W-1:0]  Z_ABS   = ABS_W'(255);
  localparam logic [LEN2_W-1:0] Z_TERM  = LEN2_W'(65025);
  localparam logic [ABS_W-1:0]  OFFSET  = ABS_W'(510);

  typedef struct packed {
    logic              neg_x;
    logic              neg_y;
    logic [ABS_W-1:0]  abs_x;
    logic [ABS_W-1:0]  abs_y;
    logic [LEN2_W-1:0] len2;
  } item_t;
endpackage

### rtl/dnfb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnfb_in_if / dnfb_out_if
// Valid/ready channels for packed bytes in and normal components out.
// ----------------------------------------------------------------------------
interface dnfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_x;
  logic [7:0] byte_y;
  modport source (output valid, output byte_x, output byte_y, input ready);
  modport sink (input valid, input byte_x, input byte_y, output ready);
endinterface

interface dnfb_out_if #(parameter int OUT_BITS = dnfb_pkg::OUT_BITS_DEF);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] normal_x;
  logic signed [OUT_BITS-1:0] normal_y;
  logic [OUT_BITS-2:0]        normal_z;
  modport source (output valid, output normal_x, output normal_y, output normal_z,
                  input ready);
  modport sink (input valid, input normal_x, input normal_y, input normal_z,
                output ready);
endinterface

### rtl/dnfb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnfb_front
// Accepts byte pairs, forms signed components and squared length.
// ----------------------------------------------------------------------------
module dnfb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          byte_x_i,
  input  logic [7:0]          byte_y_i,
  output logic                push_o,
  input  logic                push_ready_i,
  output dnfb_pkg::item_t     item_o
);
  logic            valid_q, valid_d;
  dnfb_pkg::item_t item_q, item_d;
  logic [dnfb_pkg::ABS_W-1:0] times4_x, times4_y;
  logic [2*dnfb_pkg::ABS_W-1:0] sq_x, sq_y;

  assign in_ready_o = !valid_q || push_ready_i;
  assign push_o     = valid_q;
  assign item_o     = item_q;

  always_comb begin
    times4_x = {byte_x_i[6:0], 2'b00};
    times4_y = {byte_y_i[6:0], 2'b00};
    // component is negative when the byte is below 128
    item_d.neg_x = !byte_x_i[7];
    item_d.neg_y = !byte_y_i[7];
    item_d.abs_x = byte_x_i[7] ? times4_x + dnfb_pkg::ABS_W'(2)
                               : dnfb_pkg::OFFSET - times4_x;
    item_d.abs_y = byte_y_i[7] ? times4_y + dnfb_pkg::ABS_W'(2)
                               : dnfb_pkg::OFFSET - times4_y;
    sq_x = item_d.abs_x * item_d.abs_x;
    sq_y = item_d.abs_y * item_d.abs_y;
    item_d.len2 = dnfb_pkg::LEN2_W'(sq_x) + dnfb_pkg::LEN2_W'(sq_y) + dnfb_pkg::Z_TERM;
    valid_d = in_ready_o ? in_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end
endmodule

### rtl/dnfb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnfb_fifo
// Short queue between the front and the divide pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dnfb_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            push_ready_o,
  input  dnfb_pkg::item_t item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output dnfb_pkg::item_t item_o
);
  localparam int PW = $clog2(dnfb_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(dnfb_pkg::FIFO_DEPTH + 1);

  dnfb_pkg::item_t mem_q [dnfb_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign pop_valid_o  = cnt_q != CW'(0);
  assign pop          = pop_valid_o && pop_ready_i;
  assign push_ready_o = (cnt_q != CW'(dnfb_pkg::FIFO_DEPTH)) || pop;
  assign push         = push_i && push_ready_o;
  assign item_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ((wr_q == PW'(dnfb_pkg::FIFO_DEPTH - 1)) ? PW'(0) : wr_q + PW'(1)) : wr_q;
    rd_d  = pop ? ((rd_q == PW'(dnfb_pkg::FIFO_DEPTH - 1)) ? PW'(0) : rd_q + PW'(1)) : rd_q;
    cnt_d = cnt_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  `DNFB_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(dnfb_pkg::FIFO_DEPTH), "fifo overfilled")
  `DNFB_ASSERT(a_cnt_up, clk_i, rst_ni, (push && !pop) |=> (cnt_q == $past(cnt_q) + CW'(1)), "fifo count lost a push")
  `DNFB_NEVER(a_drop, clk_i, rst_ni, push_i && !push_ready_o && pop, "fifo refused push while popping")
endmodule

### rtl/dnfb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnfb_back
// Bit-serial rounded divide by the vector length, one quotient bit per stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dnfb_back #(
  parameter int OUT_BITS = dnfb_pkg::OUT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       item_valid_i,
  output logic                       item_ready_o,
  input  dnfb_pkg::item_t            item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [OUT_BITS-1:0] normal_x_o,
  output logic signed [OUT_BITS-1:0] normal_y_o,
  output logic [OUT_BITS-2:0]        normal_z_o
);
  localparam int W     = 2 * OUT_BITS + 24;
  localparam int RSH   = 2 * (OUT_BITS - 1) + 2;
  localparam int LANES = 3;

  logic en, load;
  logic                       valid_q [0:OUT_BITS];
  logic                       negx_q  [0:OUT_BITS];
  logic                       negy_q  [0:OUT_BITS];
  logic signed [W-1:0]        l2_q    [0:OUT_BITS];
  logic signed [W-1:0]        a_q     [0:OUT_BITS][LANES];
  logic signed [W-1:0]        b_q     [0:OUT_BITS][LANES];
  logic signed [W-1:0]        r_q     [0:OUT_BITS][LANES];
  logic [OUT_BITS-1:0]        qt_q    [0:OUT_BITS][LANES];
  logic [dnfb_pkg::ABS_W-1:0] abs_in  [LANES];
  logic [OUT_BITS-1:0]        mag     [LANES];
  logic                       out_valid_q;
  logic signed [OUT_BITS-1:0] nx_q, nx_d, ny_q, ny_d;
  logic [OUT_BITS-2:0]        nz_q, nz_d;

  // the whole pipeline holds while a result waits
  assign en           = !out_valid_q || out_ready_i;
  assign item_ready_o = en;
  assign load         = en && item_valid_i;

  assign abs_in[0] = item_i.abs_x;
  assign abs_in[1] = item_i.abs_y;
  assign abs_in[2] = dnfb_pkg::Z_ABS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= OUT_BITS; s++) begin
        valid_q[s] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q[0] <= item_valid_i;
      for (int s = 1; s <= OUT_BITS; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
      out_valid_q <= valid_q[OUT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      negx_q[0] <= item_i.neg_x;
      negy_q[0] <= item_i.neg_y;
      l2_q[0]   <= W'(item_i.len2);
      for (int l = 0; l < LANES; l++) begin
        a_q[0][l]  <= W'(item_i.len2);
        b_q[0][l]  <= -W'(item_i.len2);
        r_q[0][l]  <= (W'(abs_in[l]) * W'(abs_in[l])) <<< RSH;
        qt_q[0][l] <= '0;
      end
    end
  end

  for (genvar s = 0; s < OUT_BITS; s++) begin : g_stage
    localparam int BIT = OUT_BITS - 1 - s;
    logic signed [W-1:0] term [LANES];
    logic                take [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        term[l] = a_q[s][l] + (b_q[s][l] <<< (BIT + 2)) + (l2_q[s] <<< (2 * BIT + 2));
        take[l] = term[l] <= r_q[s][l];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        negx_q[s+1] <= negx_q[s];
        negy_q[s+1] <= negy_q[s];
        l2_q[s+1]   <= l2_q[s];
        for (int l = 0; l < LANES; l++) begin
          r_q[s+1][l]  <= r_q[s][l];
          a_q[s+1][l]  <= take[l] ? term[l] : a_q[s][l];
          b_q[s+1][l]  <= take[l] ? b_q[s][l] + (l2_q[s] <<< (BIT + 1)) : b_q[s][l];
          qt_q[s+1][l] <= take[l] ? (qt_q[s][l] | (OUT_BITS'(1) << BIT)) : qt_q[s][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // clamp to the largest positive fraction
      mag[l] = qt_q[OUT_BITS][l][OUT_BITS-1] ? {1'b0, {(OUT_BITS-1){1'b1}}}
                                             : qt_q[OUT_BITS][l];
    end
    nx_d = negx_q[OUT_BITS] ? -mag[0] : mag[0];
    ny_d = negy_q[OUT_BITS] ? -mag[1] : mag[1];
    nz_d = mag[2][OUT_BITS-2:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
      nz_q <= nz_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign normal_x_o  = nx_q;
  assign normal_y_o  = ny_q;
  assign normal_z_o  = nz_q;

  `DNFB_ASSERT(a_hold_stall, clk_i, rst_ni, !en |=> (valid_q[OUT_BITS] == $past(valid_q[OUT_BITS])), "pipeline moved during stall")
  `DNFB_ASSERT(a_load_valid, clk_i, rst_ni, load |=> valid_q[0], "loaded item not marked valid")
  `DNFB_ASSERT(a_z_positive, clk_i, rst_ni, out_valid_q |-> (nz_q != '0), "z component collapsed to zero")
endmodule

### rtl/decode_normal_from_bytes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decode_normal_from_bytes
// Rebuilds a unit Q1.15 normal from packed x/z and y/z bytes.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; each quotient bit is one pipeline stage.
// Registers in order: front item, queue entry, load stage, bit stages, output.
// Stalls on the output hold the divide pipeline; the queue absorbs the front.
// Reset clears all valid flags and queue pointers; payload is not reset.
module decode_normal_from_bytes #(
  parameter int OUT_BITS = dnfb_pkg::OUT_BITS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  dnfb_in_if.sink     in_i,
  dnfb_out_if.source  out_o
);
  logic            push, push_ready, pop_valid, pop_ready;
  dnfb_pkg::item_t front_item, queue_item;

  dnfb_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .byte_x_i     (in_i.byte_x),
    .byte_y_i     (in_i.byte_y),
    .push_o       (push),
    .push_ready_i (push_ready),
    .item_o       (front_item)
  );

  dnfb_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i       (push),
    .push_ready_o (push_ready),
    .item_i       (front_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .item_o       (queue_item)
  );

  dnfb_back #(.OUT_BITS(OUT_BITS)) u_back (
    .clk_i, .rst_ni,
    .item_valid_i (pop_valid),
    .item_ready_o (pop_ready),
    .item_i       (queue_item),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .normal_x_o   (out_o.normal_x),
    .normal_y_o   (out_o.normal_y),
    .normal_z_o   (out_o.normal_z)
  );
endmodule

### tb/decode_normal_from_bytes_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decode_normal_from_bytes_tb
// Drives packed normal bytes with random gaps and output stalls, predicts
// each rounded, saturated Q1.15 component and compares every transfer.
// ----------------------------------------------------------------------------
module decode_normal_from_bytes_tb;
  localparam int OB = dnfb_pkg::OUT_BITS_DEF;
  localparam int LATENCY = OB + 3;

  typedef struct packed {
    logic [7:0] px;
    logic [7:0] py;
  } bytes_t;

  typedef struct packed {
    logic [OB-1:0] nx;
    logic [OB-1:0] ny;
    logic [OB-2:0] nz;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dnfb_in_if  in_ch ();
  dnfb_out_if #(.OUT_BITS(OB)) out_ch ();

  decode_normal_from_bytes #(.OUT_BITS(OB)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  bytes_t  pending_bytes[$];
  normal_t expected_normals[$];
  int      mismatches = 0;
  bit      quiet_phase = 0;
  bit      hold_sender = 0;
  bit      want_stall = 0;
  bit      stall_done = 0;
  int      long_stall = 0;
  int      send_gap = 0;
  int      recv_gap = 0;

  // Exact rounded magnitude of |v| * 2^(OB-1) / sqrt(len2), saturated.
  function automatic logic [OB-1:0] rounded_mag(longint unsigned absv,
                                                longint unsigned len2);
    logic [127:0] rhs;
    logic [127:0] lhs;
    longint unsigned q;
    longint unsigned cand;
    longint unsigned odd;
    rhs = 128'(absv * absv) << (2 * (OB - 1) + 2);
    q = 0;
    for (int b = OB - 1; b >= 0; b--) begin
      cand = q | (64'd1 << b);
      odd = 2 * cand - 1;
      lhs = 128'(odd * odd) * 128'(len2);
      if (lhs <= rhs) q = cand;
    end
    if (q > (64'd1 << (OB - 1)) - 1) q = (64'd1 << (OB - 1)) - 1;
    return q[OB-1:0];
  endfunction

  function automatic normal_t decode_normal(bytes_t b);
    normal_t r;
    longint vx;
    longint vy;
    longint unsigned len2;
    logic [OB-1:0] mx;
    logic [OB-1:0] my;
    logic [OB-1:0] mz;
    vx = 4 * longint'(b.px) - 510;
    vy = 4 * longint'(b.py) - 510;
    len2 = vx * vx + vy * vy + 255 * 255;
    mx = rounded_mag(vx < 0 ? -vx : vx, len2);
    my = rounded_mag(vy < 0 ? -vy : vy, len2);
    mz = rounded_mag(255, len2);
    r.nx = vx < 0 ? -mx : mx;
    r.ny = vy < 0 ? -my : my;
    r.nz = mz[OB-2:0];
    return r;
  endfunction

  // Sender: advance to the next byte pair after each transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.byte_x <= '0;
      in_ch.byte_y <= '0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_normals.push_back(decode_normal({in_ch.byte_x, in_ch.byte_y}));
        void'(pending_bytes.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered item
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 7);
        in_ch.valid <= 1'b0;
      end else if (!hold_sender && pending_bytes.size() > 0) begin
        in_ch.valid <= 1'b1;
        {in_ch.byte_x, in_ch.byte_y} <= pending_bytes[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted on its own.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_stall <= 0;
      stall_done <= 1'b0;
    end else if (long_stall > 0) begin
      long_stall <= long_stall - 1;
    end else if (want_stall && !stall_done) begin
      long_stall <= 200;
      stall_done <= 1'b1;
    end
  end

  // Receiver: random stall bursts plus one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_normals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h %h %h",
            out_ch.normal_x, out_ch.normal_y, out_ch.normal_z);
        end else begin
          normal_t e;
          e = expected_normals.pop_front();
          if (e.nx !== out_ch.normal_x || e.ny !== out_ch.normal_y ||
              e.nz !== out_ch.normal_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                       e.nx, e.ny, e.nz, out_ch.normal_x, out_ch.normal_y,
                       out_ch.normal_z);
          end
        end
      end
      if (long_stall > 0) begin
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_ch.valid || expected_normals.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] corners[4] = '{8'd0, 8'd255, 8'd127, 8'd128};
    bytes_t b;
    foreach (corners[i]) foreach (corners[j])
      pending_bytes.push_back({corners[i], corners[j]});
    pending_bytes.push_back({8'd1, 8'd254});
    pending_bytes.push_back({8'haa, 8'h55});
    pending_bytes.push_back({8'h55, 8'haa});
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    // Fill the pipeline against a long output hold-off.
    @(posedge clk_i);
    want_stall <= 1'b1;
    repeat (300) begin
      b = 16'($urandom);
      pending_bytes.push_back(b);
    end
    wait_drained();

    // Pause the sender midway until every result has come.
    repeat (600) begin
      b = 16'($urandom);
      pending_bytes.push_back(b);
    end
    while (pending_bytes.size() > 300) @(posedge clk_i);
    hold_sender <= 1'b1;
    @(posedge clk_i);
    while (in_ch.valid || expected_normals.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    hold_sender <= 1'b0;
    wait_drained();

    quiet_phase <= 1'b1;
    repeat (400) begin
      b = 16'($urandom);
      pending_bytes.push_back(b);
    end
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);

    if (mismatches == 0 && expected_normals.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
